FILE: src/escr_pkg.sv
// Shared types and constants for the expert slot cache with copy plan.
`default_nettype none
package escr_pkg;

  // Default number of tag store slots, and the width of the target slot index in a job.
  localparam int SLOTS_DEF = 64;
  localparam int TGT_W     = 10;

  // Result status codes.
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_COPY     = 3'd2;
  localparam logic [2:0] ST_DISABLED = 3'd3;
  localparam logic [2:0] ST_NO_SRC   = 3'd4;
  localparam logic [2:0] ST_GEOMETRY = 3'd5;
  localparam logic [2:0] ST_STRIDE   = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLED    = 3'd0;
  localparam logic [2:0] CFG_SLOTS      = 3'd1;
  localparam logic [2:0] CFG_SLOT_BYTES = 3'd2;
  localparam logic [2:0] CFG_GATE_BYTES = 3'd3;
  localparam logic [2:0] CFG_UP_BYTES   = 3'd4;
  localparam logic [2:0] CFG_DOWN_BYTES = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [9:0]  layer;
    logic [11:0] expert;
    logic        source_present;
    logic [39:0] gate_offset;
    logic [31:0] gate_pitch;
    logic [39:0] up_offset;
    logic [31:0] up_pitch;
    logic [39:0] down_offset;
    logic [31:0] down_pitch;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [47:0] copy_source;
    logic [47:0] copy_dest;
    logic [31:0] copy_length;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_item_t;

  typedef struct packed {
    logic        cache_enabled;
    logic [6:0]  slots_in_use;
    logic [34:0] slot_bytes;
    logic [31:0] gate_bytes;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [2:0]       status;
    logic [TGT_W-1:0] target;
    logic [11:0]      expert;
    logic [39:0]      gate_offset;
    logic [31:0]      gate_pitch;
    logic [39:0]      up_offset;
    logic [31:0]      up_pitch;
    logic [39:0]      down_offset;
    logic [31:0]      down_pitch;
    logic [31:0]      hits;
    logic [31:0]      misses;
  } job_t;

endpackage
`default_nettype wire

FILE: src/expert_slot_cache_with_copy_plan.sv
// Top level of the expert slot cache with copy plan.
//
// Requests arrive on in_valid/in_ready/in_item; results leave on
// out_valid/out_ready/out_item; registers are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data, always accepted.
// A lookup scans the tag store one slot per cycle through the single read
// port of the tag RAM before the request is classified; a hit stops the
// scan early. A disabled request skips the scan. The back turns each
// classified request into one result, or, after a multiply step, into three
// copy descriptors, one result per cycle while the receiver is ready.
// A two entry queue between them lets the front scan the next request
// while the back still delivers results.
// Reset clears the flags of every slot, both counters and all registers;
// tag contents are left as they are and never read before written.
// When the receiver stalls, the output register holds its item, the back
// stops, the queue fills and the front then stops taking requests.
`default_nettype none
module expert_slot_cache_with_copy_plan #(
  parameter int SLOTS = escr_pkg::SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire escr_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output escr_pkg::out_item_t out_item,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [34:0]    cfg_data
);
  import escr_pkg::*;

  cfg_t cfg;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t job_in;
  job_t job_out;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLED:    cfg.cache_enabled <= cfg_data[0];
        CFG_SLOTS:      cfg.slots_in_use  <= cfg_data[6:0];
        CFG_SLOT_BYTES: cfg.slot_bytes    <= cfg_data;
        CFG_GATE_BYTES: cfg.gate_bytes    <= cfg_data[31:0];
        CFG_UP_BYTES:   cfg.up_bytes      <= cfg_data[31:0];
        CFG_DOWN_BYTES: cfg.down_bytes    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  escr_front #(.SLOTS(SLOTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .job      (job_in),
    .q_full   (q_full)
  );

  escr_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (q_full),
    .pop   (pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  escr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job_out),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: src/escr_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module escr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/escr_fifo.sv
// Two entry queue that carries classified requests from the front to the back.
`default_nettype none
module escr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire escr_pkg::job_t wdata,
  output logic               full,
  input  wire logic          pop,
  output escr_pkg::job_t     rdata,
  output logic               empty
);
  import escr_pkg::*;

  job_t       store [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = store[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= !wptr;
      end
      if (pop && !empty) begin
        rptr <= !rptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: src/escr_front.sv
// Front end: accepts requests, scans the tag store and classifies each request.
`default_nettype none
module escr_front #(
  parameter int SLOTS = escr_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire escr_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire escr_pkg::in_item_t in_item,
  output logic               push,
  output escr_pkg::job_t     job,
  input  wire logic          q_full
);
  import escr_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_DECIDE} fstate_t;

  fstate_t     state;
  in_item_t    req;
  logic [CW-1:0] idx;
  logic        cmp_vld;
  logic [IW-1:0] cmp_idx;
  logic        hit_found;
  logic [IW-1:0] hit_idx;
  logic        free_found;
  logic [IW-1:0] free_idx;
  logic        dis;
  logic [31:0] hits;
  logic [31:0] misses;
  logic [SLOTS-1:0] occupied;
  logic [SLOTS-1:0] findable;

  logic [NW-1:0] n_eff;
  logic          dis_now;
  logic [21:0]   tag_rdata;
  logic          tag_we;
  logic [IW-1:0] tgt;
  logic          mark;
  logic          evict0;
  logic [31:0]   hits_next;
  logic [31:0]   misses_next;
  logic          last_cmp;
  logic          match;

  // Active slot count, clamped to the store depth.
  assign n_eff   = (NW'(cfg.slots_in_use) > NW'(SLOTS)) ? NW'(SLOTS) : NW'(cfg.slots_in_use);
  assign dis_now = !cfg.cache_enabled || (n_eff == '0);
  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_DECIDE) && !q_full;

  escr_ram #(.WIDTH(22), .DEPTH(SLOTS)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tgt),
    .wdata ({req.layer, req.expert}),
    .raddr (idx[IW-1:0]),
    .rdata (tag_rdata)
  );

  assign match    = findable[cmp_idx] && (tag_rdata == {req.layer, req.expert});
  assign last_cmp = (NW'(cmp_idx) + NW'(1)) == n_eff;

  // Classification of the scanned request.
  always_comb begin
    job             = '0;
    job.expert      = req.expert;
    job.gate_offset = req.gate_offset;
    job.gate_pitch  = req.gate_pitch;
    job.up_offset   = req.up_offset;
    job.up_pitch    = req.up_pitch;
    job.down_offset = req.down_offset;
    job.down_pitch  = req.down_pitch;
    hits_next       = hits;
    misses_next     = misses;
    tag_we          = 1'b0;
    mark            = 1'b0;
    evict0          = 1'b0;
    tgt             = free_found ? free_idx : '0;
    if (dis) begin
      job.status = ST_DISABLED;
    end else if (hit_found) begin
      hits_next  = (hits == '1) ? hits : hits + 32'd1;
      job.status = ST_HIT;
      job.target = TGT_W'(hit_idx);
    end else begin
      misses_next = (misses == '1) ? misses : misses + 32'd1;
      if (!req.mode) begin
        job.status = ST_MISS;
      end else begin
        evict0 = !free_found;
        if (!req.source_present) begin
          job.status = ST_NO_SRC;
        end else if (cfg.slot_bytes != (35'(cfg.gate_bytes) + 35'(cfg.up_bytes)
                                       + 35'(cfg.down_bytes))) begin
          job.status = ST_GEOMETRY;
        end else if ((req.gate_pitch < cfg.gate_bytes) || (req.up_pitch < cfg.up_bytes)
                     || (req.down_pitch < cfg.down_bytes)) begin
          job.status = ST_STRIDE;
        end else begin
          job.status = ST_COPY;
          job.target = TGT_W'(tgt);
          tag_we     = push;
          mark       = 1'b1;
        end
      end
    end
    job.hits   = hits_next;
    job.misses = misses_next;
  end

  // Front state machine, scan pipeline and tag store flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      cmp_vld  <= 1'b0;
      hits     <= '0;
      misses   <= '0;
      occupied <= '0;
      findable <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            req        <= in_item;
            dis        <= dis_now;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            idx        <= '0;
            cmp_vld    <= 1'b0;
            state      <= dis_now ? F_DECIDE : F_SCAN;
          end
        end
        F_SCAN: begin
          cmp_vld <= NW'(idx) < n_eff;
          cmp_idx <= idx[IW-1:0];
          if (NW'(idx) < n_eff) begin
            idx <= idx + CW'(1);
          end
          if (cmp_vld) begin
            if (match) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              state     <= F_DECIDE;
            end else begin
              if (!occupied[cmp_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= cmp_idx;
              end
              if (last_cmp) begin
                state <= F_DECIDE;
              end
            end
          end
        end
        F_DECIDE: begin
          if (!q_full) begin
            hits   <= hits_next;
            misses <= misses_next;
            // A successful load into an evicted slot 0 makes it findable again.
            if (mark) begin
              occupied[tgt] <= 1'b1;
              findable[tgt] <= 1'b1;
            end else if (evict0) begin
              findable[0] <= 1'b0;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/escr_back.sv
// Back end: turns classified requests into result items and copy descriptors.
`default_nettype none
module escr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire escr_pkg::cfg_t cfg,
  input  wire escr_pkg::job_t job,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output escr_pkg::out_item_t out_item
);
  import escr_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} bstate_t;

  bstate_t     state;
  job_t        cur;
  logic [1:0]  part;
  logic [47:0] src0;
  logic [47:0] src1;
  logic [47:0] src2;
  logic [47:0] dst;
  logic        can_load;
  logic        is_copy;
  out_item_t   res;

  assign pop      = (state == B_IDLE) && !empty;
  assign can_load = !out_valid || out_ready;
  assign is_copy  = (cur.status == ST_COPY);

  // Result item for the current part.
  always_comb begin
    res            = '0;
    res.status     = cur.status;
    res.hit_total  = cur.hits;
    res.miss_total = cur.misses;
    res.last       = 1'b1;
    if (cur.status == ST_HIT) begin
      res.slot = cur.target[5:0];
    end else if (is_copy) begin
      res.slot      = cur.target[5:0];
      res.copy_dest = dst;
      res.last      = (part == 2'd2);
      unique case (part)
        2'd0: begin
          res.copy_source = src0;
          res.copy_length = cfg.gate_bytes;
        end
        2'd1: begin
          res.copy_source = src1;
          res.copy_length = cfg.up_bytes;
        end
        default: begin
          res.copy_source = src2;
          res.copy_length = cfg.down_bytes;
        end
      endcase
    end
  end

  // Back state machine and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_valid && out_ready && (state != B_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            cur   <= job;
            part  <= 2'd0;
            state <= (job.status == ST_COPY) ? B_MUL : B_EMIT;
          end
        end
        B_MUL: begin
          src0  <= 48'(cur.gate_offset) + 48'(cur.expert) * 48'(cur.gate_pitch);
          src1  <= 48'(cur.up_offset) + 48'(cur.expert) * 48'(cur.up_pitch);
          src2  <= 48'(cur.down_offset) + 48'(cur.expert) * 48'(cur.down_pitch);
          dst   <= 48'(cur.target) * 48'(cfg.slot_bytes);
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_item  <= res;
            if (!is_copy || (part == 2'd2)) begin
              state <= B_IDLE;
            end else begin
              part <= part + 2'd1;
              dst  <= dst + 48'((part == 2'd0) ? cfg.gate_bytes : cfg.up_bytes);
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: test/tb_expert_slot_cache_with_copy_plan.sv
// Testbench for the expert slot cache with copy plan, with a built-in predictor.
`timescale 1ns / 1ps
module tb_expert_slot_cache_with_copy_plan;
  import escr_pkg::*;

  localparam int N_SLOTS    = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 100;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [34:0] cfg_data;

  expert_slot_cache_with_copy_plan dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted cache state and register copies.
  logic        cache_on;
  logic [6:0]  active_slots;
  logic [34:0] slab_slot_bytes;
  logic [31:0] part_bytes [3];
  logic [9:0]  tag_lyr [N_SLOTS];
  logic [11:0] tag_exp [N_SLOTS];
  bit          slot_busy [N_SLOTS];
  bit          slot_live [N_SLOTS];
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  in_item_t  request_q[$];
  out_item_t result_q[$];
  int        errors;
  int        send_gap;
  int        recv_stall;
  bit        long_hold;
  bit        calm;
  int        idle_cycles;

  // Clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the results of one accepted request and update the cache copy.
  function automatic void predict_request(in_item_t it);
    out_item_t   r;
    int          n;
    int          hit_slot;
    int          tgt;
    logic [63:0] off [3];
    logic [63:0] pit [3];
    logic [63:0] dst;
    r = '0;
    r.last = 1'b1;
    n = (active_slots > N_SLOTS) ? N_SLOTS : int'(active_slots);
    if (!cache_on || n == 0) begin
      r.status = ST_DISABLED;
      r.hit_total = hit_count;
      r.miss_total = miss_count;
      result_q.push_back(r);
      return;
    end
    hit_slot = -1;
    for (int i = 0; i < n; i++) begin
      if (hit_slot < 0 && slot_live[i] && tag_lyr[i] == it.layer && tag_exp[i] == it.expert)
        hit_slot = i;
    end
    if (hit_slot >= 0) begin
      if (hit_count != 32'hFFFF_FFFF) hit_count++;
      r.status = ST_HIT;
      r.slot = hit_slot[5:0];
      r.hit_total = hit_count;
      r.miss_total = miss_count;
      result_q.push_back(r);
      return;
    end
    if (miss_count != 32'hFFFF_FFFF) miss_count++;
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    if (!it.mode) begin
      r.status = ST_MISS;
      result_q.push_back(r);
      return;
    end
    // Pick the first free slot, else evict slot 0 right away.
    tgt = -1;
    for (int i = 0; i < n; i++) begin
      if (tgt < 0 && !slot_busy[i]) tgt = i;
    end
    if (tgt < 0) begin
      tgt = 0;
      slot_live[0] = 1'b0;
    end
    off[0] = 64'(it.gate_offset); pit[0] = 64'(it.gate_pitch);
    off[1] = 64'(it.up_offset);   pit[1] = 64'(it.up_pitch);
    off[2] = 64'(it.down_offset); pit[2] = 64'(it.down_pitch);
    if (!it.source_present) begin
      r.status = ST_NO_SRC;
      result_q.push_back(r);
      return;
    end
    if (64'(slab_slot_bytes) != 64'(part_bytes[0]) + 64'(part_bytes[1]) + 64'(part_bytes[2]))
    begin
      r.status = ST_GEOMETRY;
      result_q.push_back(r);
      return;
    end
    if (pit[0] < 64'(part_bytes[0]) || pit[1] < 64'(part_bytes[1])
        || pit[2] < 64'(part_bytes[2])) begin
      r.status = ST_STRIDE;
      result_q.push_back(r);
      return;
    end
    // Three copy descriptors: gate, up, down.
    dst = 64'(tgt) * 64'(slab_slot_bytes);
    for (int p = 0; p < 3; p++) begin
      r.status = ST_COPY;
      r.slot = tgt[5:0];
      r.copy_source = 48'(off[p] + 64'(it.expert) * pit[p]);
      r.copy_dest = dst[47:0];
      r.copy_length = part_bytes[p];
      r.last = (p == 2);
      result_q.push_back(r);
      dst = dst + 64'(part_bytes[p]);
    end
    tag_lyr[tgt] = it.layer;
    tag_exp[tgt] = it.expert;
    slot_busy[tgt] = 1'b1;
    slot_live[tgt] = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Request driver: holds each item until accepted, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_item);
        if (calm) send_gap = 0;
        else if ($urandom_range(0, 99) < 60) send_gap = 0;
        else if ($urandom_range(0, 99) < 90) send_gap = $urandom_range(1, 3);
        else send_gap = $urandom_range(10, 40);
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_item <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each item and stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result item, status %0d", out_item.status);
          errors++;
        end else begin
          out_item_t e;
          e = result_q.pop_front();
          check_field("status", 64'(e.status), 64'(out_item.status));
          check_field("slot", 64'(e.slot), 64'(out_item.slot));
          check_field("copy_source", 64'(e.copy_source), 64'(out_item.copy_source));
          check_field("copy_dest", 64'(e.copy_dest), 64'(out_item.copy_dest));
          check_field("copy_length", 64'(e.copy_length), 64'(out_item.copy_length));
          check_field("last", 64'(e.last), 64'(out_item.last));
          check_field("hit_total", 64'(e.hit_total), 64'(out_item.hit_total));
          check_field("miss_total", 64'(e.miss_total), 64'(out_item.miss_total));
        end
      end
      if (long_hold) begin
        long_hold = 1'b0;
        recv_stall = 300;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        recv_stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 39);
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted item on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [34:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLED:    cache_on = value[0];
      CFG_SLOTS:      active_slots = value[6:0];
      CFG_SLOT_BYTES: slab_slot_bytes = value;
      CFG_GATE_BYTES: part_bytes[0] = value[31:0];
      CFG_UP_BYTES:   part_bytes[1] = value[31:0];
      CFG_DOWN_BYTES: part_bytes[2] = value[31:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(int en, int n, logic [34:0] sb,
                         logic [31:0] g, logic [31:0] u, logic [31:0] d);
    write_reg(CFG_ENABLED, 35'(en));
    write_reg(CFG_SLOTS, 35'(n));
    write_reg(CFG_SLOT_BYTES, sb);
    write_reg(CFG_GATE_BYTES, 35'(g));
    write_reg(CFG_UP_BYTES, 35'(u));
    write_reg(CFG_DOWN_BYTES, 35'(d));
  endtask

  // Wait until every request is out and the block has gone quiet.
  task automatic drain();
    while (request_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_pitch(logic [31:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return len + 32'($urandom_range(0, 256));
    if (r < 95 || len == 0) return $urandom;
    return len - 1;
  endfunction

  function automatic in_item_t make_req(int mode, int lyr, int exn, int src);
    in_item_t it;
    it.mode = mode[0];
    it.layer = lyr[9:0];
    it.expert = exn[11:0];
    it.source_present = src[0];
    it.gate_offset = 40'({$urandom, $urandom});
    it.up_offset = 40'({$urandom, $urandom});
    it.down_offset = 40'({$urandom, $urandom});
    it.gate_pitch = pick_pitch(part_bytes[0]) | 32'h1000;
    it.up_pitch = pick_pitch(part_bytes[1]) | 32'h1000;
    it.down_pitch = pick_pitch(part_bytes[2]) | 32'h1000;
    return it;
  endfunction

  function automatic in_item_t rand_req();
    in_item_t it;
    bit       pool;
    pool = ($urandom_range(0, 99) < 80);
    it = make_req(int'($urandom_range(0, 99) < 70),
                  pool ? $urandom_range(0, 3) : $urandom_range(0, 1023),
                  pool ? $urandom_range(0, 5) : $urandom_range(0, 4095),
                  int'($urandom_range(0, 99) < 90));
    it.gate_pitch = pick_pitch(part_bytes[0]);
    it.up_pitch = pick_pitch(part_bytes[1]);
    it.down_pitch = pick_pitch(part_bytes[2]);
    return it;
  endfunction

  initial begin
    in_item_t    it;
    int          slot_plan [8];
    logic [31:0] g, u, d;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLED;
    cfg_data = '0;
    errors = 0;
    send_gap = 0;
    recv_stall = 0;
    long_hold = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    cache_on = 1'b0;
    active_slots = '0;
    slab_slot_bytes = '0;
    for (int p = 0; p < 3; p++) part_bytes[p] = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_live[i] = 1'b0;
      tag_lyr[i] = '0;
      tag_exp[i] = '0;
    end
    hit_count = '0;
    miss_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: every request answers disabled.
    request_q.push_back(make_req(1, 5, 7, 1));
    drain();
    set_cfg(1, 0, 35'h600, 32'h100, 32'h200, 32'h300);
    request_q.push_back(make_req(0, 5, 7, 1));
    drain();
    write_reg(CFG_SLOTS, 35'd4);

    // Miss, failed load keeps the slot free, load, hits, stride check.
    request_q.push_back(make_req(0, 5, 7, 1));
    request_q.push_back(make_req(1, 5, 7, 0));
    request_q.push_back(make_req(1, 5, 7, 1));
    request_q.push_back(make_req(0, 5, 7, 1));
    request_q.push_back(make_req(1, 5, 7, 1));
    it = make_req(1, 6, 6, 1);
    it.gate_pitch = 32'hFF;
    request_q.push_back(it);
    // Field extremes.
    it = make_req(1, 1023, 4095, 1);
    it.gate_offset = '1; it.up_offset = '1; it.down_offset = '1;
    it.gate_pitch = '1;  it.up_pitch = '1;  it.down_pitch = '1;
    request_q.push_back(it);
    it = make_req(1, 0, 0, 1);
    it.gate_offset = '0; it.up_offset = '0; it.down_offset = '0;
    it.gate_pitch = 32'h100; it.up_pitch = 32'h200; it.down_pitch = 32'h300;
    request_q.push_back(it);
    request_q.push_back(make_req(1, 3, 3, 1));
    // Full: eviction of slot 0, then a failed load that evicts it again.
    request_q.push_back(make_req(1, 9, 9, 1));
    request_q.push_back(make_req(0, 5, 7, 1));
    request_q.push_back(make_req(1, 8, 8, 0));
    request_q.push_back(make_req(0, 9, 9, 1));
    request_q.push_back(make_req(1, 10, 10, 1));
    drain();

    // Fewer active slots: entries above the limit are stale.
    write_reg(CFG_SLOTS, 35'd2);
    request_q.push_back(make_req(0, 1023, 4095, 1));
    request_q.push_back(make_req(0, 3, 3, 1));
    drain();
    // Slot bytes that do not match the parts.
    write_reg(CFG_SLOT_BYTES, 35'h4_0000_0000);
    request_q.push_back(make_req(1, 12, 12, 1));
    drain();
    // Largest parts, slot count above the store size.
    set_cfg(1, 127, 35'h2_FFFF_FFFD, '1, '1, '1);
    it = make_req(1, 1023, 4095, 1);
    it.gate_pitch = '1; it.up_pitch = '1; it.down_pitch = '1;
    request_q.push_back(it);
    request_q.push_back(make_req(0, 1023, 4095, 1));
    drain();

    // Random phases over several settings.
    slot_plan = '{3, 8, 1, 127, 16, 64, 2, 5};
    for (int ph = 0; ph < 8; ph++) begin
      g = $urandom_range(1, 4096);
      u = $urandom_range(1, 4096);
      d = $urandom_range(1, 4096);
      set_cfg(int'(ph != 6), slot_plan[ph],
              35'(g) + 35'(u) + 35'(d) + 35'(ph == 4), g, u, d);
      calm = (ph == 2 || ph == 7);
      if (ph == 0) long_hold = 1'b1;
      for (int k = 0; k < 40; k++) request_q.push_back(rand_req());
      drain();
    end

    if (result_q.size() != 0) errors++;
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
